>>> rtl/pkcdr_pkg.sv
// Package for per_key_counter_delta_rate: table geometry, status codes,
// sizing constants. No dependencies.
package pkcdr_pkg;
  localparam int KEYS = 256;
  localparam int IDX_W = $clog2(KEYS);
  localparam int CNT_W = $clog2(KEYS + 1);
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // One table row: key, last sample, timestamp.
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] value;
    logic [31:0] seconds;
    logic [29:0] nanos;
  } entry_t;
endpackage

>>> rtl/pkcdr_div.sv
// Restoring divider: floor(num / den) for a 128-bit numerator whose upper
// part is below den, one quotient bit per cycle. Uses pkcdr_pkg.
module pkcdr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [62:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import pkcdr_pkg::*;

  logic [63:0] rem_r, rem_nxt, lo_r, lo_nxt, quo_r, quo_nxt;
  logic [62:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] sh;

  always_comb begin
    rem_nxt = rem_r; lo_nxt = lo_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r, lo_r[63]};
    if (start) begin
      rem_nxt = num_hi; lo_nxt = num_lo; quo_nxt = '0;
      cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      lo_nxt = {lo_r[62:0], 1'b0};
      if (sh >= {2'b00, den_r}) begin
        rem_nxt = 64'(sh - {2'b00, den_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) den_r <= den;
    rem_r <= rem_nxt; lo_r <= lo_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

>>> rtl/pkcdr_table.sv
// Entry table: synchronous memory of rows with one read and one write port, plus a fill count.
// Rows fill in order and are never freed, so index < count means used.
// Uses pkcdr_pkg.
module pkcdr_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pkcdr_pkg::IDX_W-1:0] rd_addr,
  output pkcdr_pkg::entry_t        rd_data,
  input  logic                     wr_en,
  input  logic [pkcdr_pkg::IDX_W-1:0] wr_addr,
  input  pkcdr_pkg::entry_t        wr_data,
  input  logic                     append,
  output logic [pkcdr_pkg::CNT_W-1:0] count
);
  import pkcdr_pkg::*;

  entry_t mem [KEYS];
  entry_t rd_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (append) count_r <= count_r + CNT_W'(1);
  end

  assign rd_data = rd_r;
  assign count   = count_r;
endmodule

>>> rtl/per_key_counter_delta_rate.sv
// Per-key counter change and rate: top level.
// Uses pkcdr_pkg, pkcdr_table, pkcdr_div.
//
// Usage:
//   Input channel: raise start with in_* fields while busy is low; the
//   transfer happens at that edge and busy rises the next cycle.
//   Result channel: out_valid pulses for one cycle with out_status and
//   out_result_value; the receiver cannot stall and must take it then.
// Operation:
//   The key is searched linearly through a registered-read table memory,
//   one entry per cycle over the filled rows (used rows fill from index 0
//   and are never freed, so a fill count replaces per-entry used bits).
//   A hit reads, modifies and writes back the row; a miss appends a row or
//   flags full. Rate mode: 64-step restoring divider, diff*1e9 / elapsed_ns.
// Sequencing:
//   A miss scans every filled row before its result strobe, a hit stops at
//   its row; a computed rate then passes S_MUL, S_MUL2, the divider load
//   and 64 divider steps. Busy drops with the strobe, one item at a time.
// Reset:
//   Synchronous active-low rst_n empties the table (fill count to zero)
//   and idles the controller; no clearing pass is needed.
module per_key_counter_delta_rate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_item_key,
  input  logic [63:0] in_sample_value,
  input  logic [31:0] in_stamp_seconds,
  input  logic [29:0] in_stamp_nanos,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_result_value
);
  import pkcdr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1; // entry at addr_r being read
  localparam logic [2:0] S_MUL  = 3'd2; // form partial products; reject bad elapsed time
  localparam logic [2:0] S_MUL2 = 3'd3; // combine partial products
  localparam logic [2:0] S_DIV  = 3'd4; // wait for divider

  logic [2:0]       state_r, state_nxt;
  logic             op_r;
  logic [31:0]      key_r;
  logic [63:0]      val_r;
  logic [31:0]      sec_r;
  logic [29:0]      ns_r;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic [63:0]      diff_r;
  logic [61:0]      plo_r, phi_r;
  logic [63:0]      elap_r;
  logic             bad_r;
  logic             sat;

  entry_t           rd;
  logic [CNT_W-1:0] count;
  logic             wr_en, append;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             div_start, div_done;
  logic [63:0]      div_quo;

  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [63:0]      ores_r, ores_nxt;

  logic [63:0]      sec_ns;
  logic [63:0]      t_full;
  logic [95:0]      prod;

  pkcdr_table u_table (
    .clk, .rst_n,
    .rd_addr(addr_nxt[IDX_W-1:0]), .rd_data(rd),
    .wr_en, .wr_addr, .wr_data, .append, .count
  );

  // The product is stable through S_MUL2, so the divider loads it directly.
  pkcdr_div u_div (
    .clk, .rst_n, .start(div_start),
    .num_hi(64'(prod[95:64])), .num_lo(prod[63:0]), .den(elap_r[62:0]),
    .done(div_done), .quo(div_quo)
  );

  assign wr_data = '{key: key_r, value: val_r, seconds: sec_r, nanos: ns_r};
  assign sec_ns  = 64'(sec_r - rd.seconds) * 64'(NS_PER_SEC);
  assign t_full  = sec_ns + 64'(ns_r);
  assign prod    = {phi_r, 32'd0} + 96'(plo_r);

  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r;
    wr_en = 1'b0; append = 1'b0; wr_addr = addr_r[IDX_W-1:0];
    div_start = 1'b0;
    ov_nxt = 1'b0; os_nxt = os_r; ores_nxt = ores_r;
    unique case (state_r)
      S_IDLE: begin
        addr_nxt = '0;
        if (start) state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (addr_r == count) begin
          // miss: append or flag full
          ov_nxt = 1'b1; ores_nxt = '0; state_nxt = S_IDLE;
          if (count == CNT_W'(KEYS)) begin
            os_nxt = ST_FULL;
          end else begin
            os_nxt = ST_FIRST; wr_en = 1'b1; append = 1'b1;
          end
        end else if (rd.key == key_r) begin
          wr_en = 1'b1;
          ores_nxt = '0;
          if (rd.seconds == 32'd0 || rd.value > val_r) begin
            ov_nxt = 1'b1; os_nxt = ST_NONE; state_nxt = S_IDLE;
          end else if (!op_r) begin
            ov_nxt = 1'b1; os_nxt = ST_VALID; ores_nxt = val_r - rd.value;
            state_nxt = S_IDLE;
          end else if (rd.seconds > sec_r ||
                       (rd.seconds == sec_r && rd.nanos >= ns_r)) begin
            ov_nxt = 1'b1; os_nxt = ST_NONE; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end else begin
          addr_nxt = addr_r + CNT_W'(1);
        end
      end
      S_MUL: begin
        if (bad_r) begin
          ov_nxt = 1'b1; os_nxt = ST_NONE; ores_nxt = '0; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (sat) begin
          ov_nxt = 1'b1; os_nxt = ST_VALID; ores_nxt = '1; state_nxt = S_IDLE;
        end else begin
          div_start = 1'b1; state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ov_nxt = 1'b1; os_nxt = ST_VALID; ores_nxt = div_quo;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    os_r <= os_nxt; ores_r <= ores_nxt;
    if (state_r == S_IDLE && start) begin
      op_r <= in_operation; key_r <= in_item_key; val_r <= in_sample_value;
      sec_r <= in_stamp_seconds; ns_r <= in_stamp_nanos;
    end
    if (state_r == S_SRCH) begin
      // capture diff and elapsed time
      diff_r <= val_r - rd.value;
      elap_r <= t_full - 64'(rd.nanos);
      bad_r  <= t_full <= 64'(rd.nanos);
    end
    if (state_r == S_MUL) begin
      plo_r <= 62'(64'(diff_r[31:0]) * 64'(NS_PER_SEC));
      phi_r <= 62'(64'(diff_r[63:32]) * 64'(NS_PER_SEC));
    end
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  // Saturation test needs the combined high part; compare it as it forms.
  assign sat = 64'(prod[95:64]) >= elap_r;

  assign busy             = state_r != S_IDLE;
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_result_value = ores_r;
endmodule
